[rtl/core/hsltd_pkg.sv]
// Shared types and constants for the header/sync/length/tail deframer.
// No dependencies.
`default_nettype none
package hsltd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int TYPE_W = 2;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_HDR_SLOTS = 4;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_TABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_TABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE    = 2'd3;

    localparam logic [CFG_W-1:0]  HEADER_TABLE_RST = 32'h0000_0000;
    localparam logic [CFG_W-1:0]  LENGTH_TABLE_RST = 32'h0000_0000;
    localparam logic [BYTE_W-1:0] SYNC_BYTE_RST    = 8'h81;
    localparam logic [BYTE_W-1:0] TAIL_BYTE_RST    = 8'hDA;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef logic [LEN_W:0] len_sum_t;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_SYNC  = 6'b000010,
        PH_LEN   = 6'b000100,
        PH_BODY  = 6'b001000,
        PH_TAIL  = 6'b010000,
        PH_DRAIN = 6'b100000
    } phase_t;

endpackage
`default_nettype wire

[rtl/core/head_sync_length_tail_deframer_top.sv]
// Byte-stream deframer: header, sync, length, body and tail check, body replay.
// Depends on hsltd_pkg.
//
// Takes one received byte per beat on the s_ side. A byte is taken every cycle while a
// frame is being received (header, sync, length, body, tail) and the output register is
// free. When the tail byte arrives, the stored body (length + 2 bytes) is replayed on
// the m_ side from the single-port body memory at one beat per cycle while m_tready is
// high; s_tready stays low while the body is replayed, and output stalls lengthen it. A
// byte out of sequence produces one error beat (tuser kind set, tlast set) and returns
// the parser to idle; unmatched bytes while idle are dropped. The body memory needs no
// clearing: only entries written by the current frame are read.
`default_nettype none
module head_sync_length_tail_deframer_top #(
    parameter int NUM_FRAME_TYPES = 4,
    parameter int BODY_DEPTH      = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [hsltd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hsltd_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,  // [7:0] rx_byte
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [15:0]                             m_tdata,  // [7:0] frame_byte,
                                                              // [13:8] byte_position
    output logic [2:0]                              m_tuser,  // [0] result_kind,
                                                              // [2:1] frame_type
    output logic                                    m_tlast   // last_of_frame
);
    import hsltd_pkg::*;

    localparam int AW = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1;
    localparam int CW = $clog2(BODY_DEPTH + 1);
    localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(BODY_DEPTH - 2);

    // configuration
    logic [CFG_W-1:0]  header_table_reg, length_table_reg;
    logic [BYTE_W-1:0] sync_byte_reg, tail_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_table_reg <= HEADER_TABLE_RST;
            length_table_reg <= LENGTH_TABLE_RST;
            sync_byte_reg    <= SYNC_BYTE_RST;
            tail_byte_reg    <= TAIL_BYTE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_HEADER_TABLE: header_table_reg <= cfg_wdata;
                REG_LENGTH_TABLE: length_table_reg <= cfg_wdata;
                REG_SYNC_BYTE:    sync_byte_reg    <= cfg_wdata[BYTE_W-1:0];
                REG_TAIL_BYTE:    tail_byte_reg    <= cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // parser state
    phase_t            phase_reg, phase_next;
    logic [TYPE_W-1:0] type_reg, type_next;
    logic [LEN_W-1:0]  exp_len_reg, exp_len_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic [LEN_W-1:0]  pend_pos_reg, pend_pos_next;
    logic              pend_last_reg, pend_last_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [TYPE_W-1:0] out_type_reg, out_type_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [LEN_W-1:0]  out_pos_reg, out_pos_next;
    logic              out_last_reg, out_last_next;

    // body memory
    logic [BYTE_W-1:0] body_mem [BODY_DEPTH];
    logic [BYTE_W-1:0] mem_q_reg;
    logic              mem_we, mem_re;

    logic              out_free, s_beat, load;
    logic              hdr_hit;
    logic [TYPE_W-1:0] hdr_idx;
    logic [BYTE_W-1:0] hdr_len, hdr_len_sat;
    logic [CW-1:0]     fill_inc, rd_inc;
    len_sum_t          body_total;

    always_comb begin
        hdr_hit = 1'b0;
        hdr_idx = '0;
        for (int i = NUM_FRAME_TYPES - 1; i >= 0; i--) begin
            if (i < NUM_HDR_SLOTS
                && header_table_reg[BYTE_W*i +: BYTE_W] == s_tdata) begin
                hdr_hit = 1'b1;
                hdr_idx = TYPE_W'(i);
            end
        end
        hdr_len     = length_table_reg[BYTE_W*hdr_idx +: BYTE_W];
        hdr_len_sat = (hdr_len > MAX_LEN) ? MAX_LEN : hdr_len;
    end

    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (phase_reg != PH_DRAIN) && out_free;
    assign s_beat     = s_tvalid && s_tready;
    assign load       = pend_reg && out_free;
    assign fill_inc   = fill_reg + CW'(1);
    assign rd_inc     = rd_idx_reg + CW'(1);
    assign body_total = len_sum_t'(exp_len_reg) + len_sum_t'(2);

    always_comb begin
        phase_next     = phase_reg;
        type_next      = type_reg;
        exp_len_next   = exp_len_reg;
        fill_next      = fill_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        pend_pos_next  = pend_pos_reg;
        pend_last_next = pend_last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_type_next  = out_type_reg;
        out_byte_next  = out_byte_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (s_beat) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (hdr_hit) begin
                        type_next    = hdr_idx;
                        exp_len_next = hdr_len_sat[LEN_W-1:0];
                        fill_next    = '0;
                        phase_next   = PH_SYNC;
                    end
                end
                PH_SYNC: begin
                    if (s_tdata == sync_byte_reg) phase_next = PH_LEN;
                end
                PH_LEN: begin
                    if (s_tdata == BYTE_W'(exp_len_reg)) begin
                        phase_next = PH_BODY;
                        fill_next  = '0;
                    end
                end
                PH_BODY: begin
                    mem_we    = 1'b1;
                    fill_next = fill_inc;
                    if (len_sum_t'(fill_inc) >= body_total) phase_next = PH_TAIL;
                end
                PH_TAIL: begin
                    if (s_tdata == tail_byte_reg) begin
                        phase_next  = PH_DRAIN;
                        rd_idx_next = '0;
                    end
                end
                default: ;
            endcase

            // sequence error
            if ((phase_reg == PH_SYNC && s_tdata != sync_byte_reg)
                || (phase_reg == PH_LEN && s_tdata != BYTE_W'(exp_len_reg))
                || (phase_reg == PH_TAIL && s_tdata != tail_byte_reg)) begin
                m_valid_next  = 1'b1;
                out_kind_next = KIND_ERROR;
                out_type_next = type_reg;
                out_byte_next = '0;
                out_pos_next  = '0;
                out_last_next = 1'b1;
                phase_next    = PH_IDLE;
                type_next     = '0;
                exp_len_next  = '0;
                fill_next     = '0;
            end
        end

        if (phase_reg == PH_DRAIN) begin
            if (load) begin
                m_valid_next  = 1'b1;
                out_kind_next = KIND_DATA;
                out_type_next = type_reg;
                out_byte_next = mem_q_reg;
                out_pos_next  = pend_pos_reg;
                out_last_next = pend_last_reg;
                pend_next     = 1'b0;
            end
            if (rd_idx_reg != fill_reg && (!pend_reg || load)) begin
                mem_re         = 1'b1;
                pend_next      = 1'b1;
                pend_pos_next  = LEN_W'(rd_idx_reg);
                pend_last_next = (rd_inc == fill_reg);
                rd_idx_next    = rd_inc;
            end else if (rd_idx_reg == fill_reg && !pend_reg) begin
                phase_next   = PH_IDLE;
                type_next    = '0;
                exp_len_next = '0;
                fill_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            type_reg    <= '0;
            exp_len_reg <= '0;
            fill_reg    <= '0;
            rd_idx_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            type_reg    <= type_next;
            exp_len_reg <= exp_len_next;
            fill_reg    <= fill_next;
            rd_idx_reg  <= rd_idx_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_pos_reg  <= pend_pos_next;
        pend_last_reg <= pend_last_next;
        out_kind_reg  <= out_kind_next;
        out_type_reg  <= out_type_next;
        out_byte_reg  <= out_byte_next;
        out_pos_reg   <= out_pos_next;
        out_last_reg  <= out_last_next;
    end

    // writes and reads never fall in the same phase, so no forwarding
    always_ff @(posedge aclk) begin
        if (mem_we) body_mem[fill_reg[AW-1:0]] <= s_tdata;
        if (mem_re) mem_q_reg <= body_mem[rd_idx_reg[AW-1:0]];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_pos_reg, out_byte_reg};
    assign m_tuser  = {out_type_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for head_sync_length_tail_deframer_top: byte stream in,
// frame body or error beats out, checked against an in-bench parser model.
// Depends on hsltd_pkg and the deframer RTL.
module tb;
    import hsltd_pkg::*;

    typedef struct packed {
        logic             kind;
        logic [TYPE_W-1:0] ftype;
        logic [7:0]       data;
        logic [LEN_W-1:0] pos;
        logic             last;
    } beat_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;

    // parser shadow: configuration
    logic [CFG_W-1:0]  hdr_tbl = HEADER_TABLE_RST;
    logic [CFG_W-1:0]  len_tbl = LENGTH_TABLE_RST;
    logic [7:0]        sync_b  = SYNC_BYTE_RST;
    logic [7:0]        tail_b  = TAIL_BYTE_RST;
    // parser shadow: state
    phase_t            ph = PH_IDLE;
    logic [TYPE_W-1:0] cur_type = '0;
    logic [LEN_W-1:0]  want_len = '0;
    logic [LEN_W:0]    fill_cnt = '0;
    logic [7:0]        body_mem [64];

    logic [7:0] tx_bytes [$];
    beat_t      frame_beats [$];
    int         bytes_queued = 0;
    int         tx_gap = 0;
    int         rx_stall = 0;
    int         mismatches = 0;
    beat_t      seen_beat;
    beat_t      want_beat;

    head_sync_length_tail_deframer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] rx_byte
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [7:0] frame_byte, [13:8] byte_position
        .m_tuser   (m_tuser),   // [0] result_kind, [2:1] frame_type
        .m_tlast   (m_tlast)
    );

    always #10 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic return_idle();
        ph = PH_IDLE;
        cur_type = '0;
        want_len = '0;
        fill_cnt = '0;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        int          n;
        bit          hit;
        bit          emit;
        bit          fault;
        logic [7:0]  len;
        beat_t       bt;
        hit = 1'b0;
        emit = 1'b0;
        fault = 1'b0;
        case (ph)
            PH_IDLE: begin
                for (int i = 0; i < NUM_HDR_SLOTS; i++) begin
                    if (!hit && hdr_tbl[8*i +: 8] == b) begin
                        hit = 1'b1;
                        len = len_tbl[8*i +: 8];
                        if (len > 8'd62) len = 8'd62;
                        cur_type = i[TYPE_W-1:0];
                        want_len = len[LEN_W-1:0];
                        fill_cnt = '0;
                        ph = PH_SYNC;
                    end
                end
            end
            PH_SYNC: begin
                if (b == sync_b) ph = PH_LEN;
                else fault = 1'b1;
            end
            PH_LEN: begin
                if (b == {2'b00, want_len}) begin
                    ph = PH_BODY;
                    fill_cnt = '0;
                end else begin
                    fault = 1'b1;
                end
            end
            PH_BODY: begin
                if (int'(fill_cnt) < int'(want_len) + 2) begin
                    body_mem[fill_cnt[5:0]] = b;
                    fill_cnt = fill_cnt + 1'b1;
                    if (int'(fill_cnt) >= int'(want_len) + 2) ph = PH_TAIL;
                end else begin
                    ph = PH_TAIL;
                    if (b == tail_b) emit = 1'b1;
                    else fault = 1'b1;
                end
            end
            PH_TAIL: begin
                if (b == tail_b) emit = 1'b1;
                else fault = 1'b1;
            end
            default: fault = 1'b1;
        endcase
        if (fault) begin
            bt = '{kind: KIND_ERROR, ftype: cur_type, data: 8'h00, pos: '0, last: 1'b1};
            frame_beats.push_back(bt);
            return_idle();
        end else if (emit) begin
            n = int'(fill_cnt);
            for (int i = 0; i < n; i++) begin
                bt = '{kind: KIND_DATA, ftype: cur_type, data: body_mem[i],
                       pos: i[LEN_W-1:0], last: (i + 1 == n)};
                frame_beats.push_back(bt);
            end
            return_idle();
        end
    endtask

    // byte source
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) parse_rx_byte(s_tdata);
            if (s_tvalid && !s_tready) begin
                // hold current beat
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (tx_bytes.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= tx_bytes.pop_front();
                tx_gap <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_beat = '{kind: m_tuser[0], ftype: m_tuser[2:1], data: m_tdata[7:0],
                              pos: m_tdata[13:8], last: m_tlast};
                if (frame_beats.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected beat kind=%0d type=%0d byte=%02h pos=%0d last=%0d",
                                 $realtime, seen_beat.kind, seen_beat.ftype, seen_beat.data,
                                 seen_beat.pos, seen_beat.last);
                    mismatches++;
                end else begin
                    want_beat = frame_beats.pop_front();
                    if (seen_beat.kind !== want_beat.kind || seen_beat.ftype !== want_beat.ftype ||
                        seen_beat.data !== want_beat.data || seen_beat.pos !== want_beat.pos ||
                        seen_beat.last !== want_beat.last) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch exp kind=%0d type=%0d byte=%02h pos=%0d last=%0d, got kind=%0d type=%0d byte=%02h pos=%0d last=%0d",
                                     $realtime, want_beat.kind, want_beat.ftype, want_beat.data,
                                     want_beat.pos, want_beat.last, seen_beat.kind,
                                     seen_beat.ftype, seen_beat.data, seen_beat.pos,
                                     seen_beat.last);
                        mismatches++;
                    end
                end
            end
            if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_stall <= pick_gap();
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        bytes_queued++;
    endtask

    // bytes listed first-to-last from the high end of v
    task automatic push_hex(input logic [255:0] v, input int n);
        for (int k = 0; k < n; k++) queue_byte(v[8*(n-1-k) +: 8]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_HEADER_TABLE: hdr_tbl = val;
            REG_LENGTH_TABLE: len_tbl = val;
            REG_SYNC_BYTE:    sync_b = val[7:0];
            REG_TAIL_BYTE:    tail_b = val[7:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_config(input logic [31:0] h, input logic [31:0] l,
                               input logic [7:0] s, input logic [7:0] t);
        write_reg(REG_HEADER_TABLE, h);
        write_reg(REG_LENGTH_TABLE, l);
        write_reg(REG_SYNC_BYTE, {24'h0, s});
        write_reg(REG_TAIL_BYTE, {24'h0, t});
        @(negedge aclk);
    endtask

    task automatic add_frame(input bit broken);
        int         t;
        int         e;
        int         n;
        int         idx;
        int         r;
        logic [7:0] hb;
        logic [7:0] fb [$];
        t = $urandom_range(0, 3);
        hb = hdr_tbl[8*t +: 8];
        e = t;
        for (int i = 3; i >= 0; i--) if (hdr_tbl[8*i +: 8] == hb) e = i;
        n = int'(len_tbl[8*e +: 8]);
        if (n > 62) n = 62;
        fb.push_back(hb);
        fb.push_back(sync_b);
        fb.push_back(n[7:0]);
        repeat (n + 2) begin
            r = $urandom_range(0, 9);
            fb.push_back(r == 0 ? sync_b : r == 1 ? tail_b : 8'($urandom_range(0, 255)));
        end
        fb.push_back(tail_b);
        if (broken) begin
            r = $urandom_range(0, 2);
            idx = (r == 0) ? 1 : (r == 1) ? 2 : fb.size() - 1;
            fb[idx] = 8'($urandom_range(0, 255));
        end
        foreach (fb[i]) queue_byte(fb[i]);
    endtask

    task automatic run_random(input int budget);
        int start;
        int r;
        start = bytes_queued;
        while (bytes_queued - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 1))
                        queue_byte(hdr_tbl[8*$urandom_range(0, 3) +: 8]);
                    else
                        queue_byte(8'($urandom_range(0, 255)));
                end
            end else begin
                add_frame(r < 30);
            end
        end
    endtask

    task automatic wait_quiet();
        do @(negedge aclk);
        while (tx_bytes.size() != 0 || s_tvalid || frame_beats.size() != 0);
    endtask

    // drain, close any partial frame, then let the replay finish before reconfiguring
    task automatic finish_phase();
        wait_quiet();
        case (ph)
            PH_SYNC: queue_byte(~sync_b);
            PH_LEN:  queue_byte(8'hFF);
            PH_BODY: repeat (int'(want_len) + 3 - int'(fill_cnt)) queue_byte(tail_b);
            PH_TAIL: queue_byte(tail_b);
            default: ;
        endcase
        wait_quiet();
        repeat (80) @(negedge aclk);
    endtask

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset register values
        push_hex(48'h00_81_00_AB_CD_DA, 6);
        run_random(20);
        finish_phase();

        // duplicate header entry, zero length, saturated length
        load_config(32'h5A_3C_3C_A5, 32'hC8_05_00_03, 8'h7E, 8'h7F);
        push_hex(56'h11_3C_7E_00_7E_7F_7F, 7);
        push_hex(72'hA5_7E_03_00_FF_7F_7E_55_7F, 9);
        push_hex(40'hA5_A5_5A_7E_C8, 5);
        run_random(70);
        finish_phase();

        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 8'hFF);
        run_random(60);
        finish_phase();

        load_config(32'h0000_0000, 32'h0000_0000, 8'hFF, 8'h00);
        run_random(60);
        finish_phase();

        load_config($urandom,
                    {8'($urandom_range(0, 9)), 8'($urandom_range(0, 9)),
                     8'($urandom_range(0, 9)), 8'($urandom_range(0, 9))},
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random(90);
        finish_phase();

        if (mismatches == 0 && frame_beats.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[head_sync_length_tail_deframer_top.f]
rtl/core/hsltd_pkg.sv
rtl/core/head_sync_length_tail_deframer_top.sv
tb/tb.sv
